// ----- design/tga_pkg.sv -----
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants for the image payload run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

	localparam int PIX_W = 22;
	localparam logic [PIX_W-1:0] MAX_PIXELS = 22'd2097152;

	localparam logic [1:0] REG_COLOR_FORMAT = 2'd0;
	localparam logic [1:0] REG_IMAGE_KIND   = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

	localparam logic [1:0] FMT_555 = 2'd0;
	localparam logic [1:0] FMT_MIX = 2'd1;
	localparam logic [1:0] FMT_565 = 2'd2;

	localparam logic [1:0] KIND_RAW  = 2'd0;
	localparam logic [1:0] KIND_RLE  = 2'd1;
	localparam logic [1:0] KIND_GRAY = 2'd2;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	typedef struct packed {
		logic [1:0]       color_format;
		logic [1:0]       image_kind;
		logic [PIX_W-1:0] pixel_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		logic [1:0] fmt;
		logic [7:0] count;
		logic       last;
	} pix_cmd_t;

endpackage

// ----- design/tga_front.sv -----
// ----------------------------------------------------------------------------
// tga_front
// Byte parser: packet headers, pixel assembly and frame pixel budget.
// ----------------------------------------------------------------------------
module tga_front import tga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       command,
	input  logic [7:0] data_byte,
	input  cfg_t       cfg,
	output logic       emit,
	output pix_cmd_t   cmd
);

	typedef enum logic [1:0] {PH_HEADER, PH_RUN, PH_RAW} phase_t;

	phase_t           phase_q, phase_d;
	logic [7:0]       left_q, left_d;
	logic [1:0]       pos_q, pos_d;
	logic [PIX_W-1:0] budget_q, budget_d;
	logic [7:0]       b_q, g_q;
	logic             collecting, coll_done, b_en, g_en;
	logic [7:0]       run_cnt, count;
	logic [1:0]       px_fmt;
	logic [7:0]       px_b, px_g;

	assign coll_done = pos_q[1];

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		pos_d      = pos_q;
		budget_d   = budget_q;
		emit       = 1'b0;
		collecting = 1'b0;
		run_cnt    = 8'd1;
		px_fmt     = cfg.color_format;
		px_b       = b_q;
		px_g       = g_q;
		b_en       = 1'b0;
		g_en       = 1'b0;
		count      = 8'd1;
		if (in_valid) begin
			if (command == CMD_FRAME) begin
				budget_d = (cfg.pixel_count > MAX_PIXELS) ? MAX_PIXELS : cfg.pixel_count;
				phase_d  = PH_HEADER;
				left_d   = 8'd0;
				pos_d    = 2'd0;
			end else if (budget_q != '0) begin
				case (cfg.image_kind)
					KIND_GRAY: begin
						emit   = 1'b1;
						px_b   = data_byte;
						px_g   = data_byte;
						px_fmt = FMT_565;
					end
					KIND_RLE: begin
						if (phase_q == PH_HEADER) begin
							phase_d = data_byte[7] ? PH_RUN : PH_RAW;
							left_d  = {1'b0, data_byte[6:0]} + 8'd1;
						end else begin
							collecting = 1'b1;
							emit       = coll_done;
							if (coll_done) begin
								if (phase_q == PH_RUN) begin
									run_cnt = left_q;
									phase_d = PH_HEADER;
									left_d  = 8'd0;
								end else if (left_q <= 8'd1) begin
									phase_d = PH_HEADER;
									left_d  = 8'd0;
								end else begin
									left_d = left_q - 8'd1;
								end
							end
						end
					end
					default: begin
						collecting = 1'b1;
						emit       = coll_done;
					end
				endcase
				if (collecting) begin
					case (pos_q)
						2'd0: begin
							b_en  = 1'b1;
							pos_d = 2'd1;
						end
						2'd1: begin
							g_en  = 1'b1;
							pos_d = 2'd2;
						end
						default: pos_d = 2'd0;
					endcase
				end
				if (emit) begin
					count    = ({{(PIX_W-8){1'b0}}, run_cnt} > budget_q) ? budget_q[7:0] : run_cnt;
					budget_d = budget_q - {{(PIX_W-8){1'b0}}, count};
				end
			end
		end
	end

	assign cmd.b     = px_b;
	assign cmd.g     = px_g;
	assign cmd.r     = data_byte;
	assign cmd.fmt   = px_fmt;
	assign cmd.count = count;
	assign cmd.last  = (budget_d == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			left_q   <= 8'd0;
			pos_q    <= 2'd0;
			budget_q <= '0;
		end else begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			pos_q    <= pos_d;
			budget_q <= budget_d;
		end
	end

	always_ff @(posedge clk) begin
		if (b_en) begin
			b_q <= data_byte;
		end
		if (g_en) begin
			g_q <= data_byte;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (cmd.count != 8'd0) && (cmd.count <= 8'd128))
		else $error("repeat count out of range");

	a_last_spends_budget: assert property (@(posedge clk) disable iff (!arst_n)
		emit && cmd.last |=> budget_q == '0)
		else $error("frame done with budget left");

	a_budget_max: assert property (@(posedge clk) disable iff (!arst_n)
		budget_q <= MAX_PIXELS)
		else $error("budget above maximum");

endmodule

// ----- design/tga_fifo.sv -----
// ----------------------------------------------------------------------------
// tga_fifo
// Two-entry queue of pixel commands between parser and packer.
// ----------------------------------------------------------------------------
module tga_fifo import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  pix_cmd_t wr_data,
	input  logic     rd_en,
	output pix_cmd_t rd_data,
	output logic     full,
	output logic     empty
);

	pix_cmd_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- design/tga_back.sv -----
// ----------------------------------------------------------------------------
// tga_back
// Pixel packer and result register.
// ----------------------------------------------------------------------------
module tga_back import tga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  pix_cmd_t    cmd,
	output logic        cmd_take,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] pixel_word,
	output logic [7:0]  repeat_count,
	output logic        frame_done
);

	logic        valid_q;
	logic [15:0] word_q, word;
	logic [7:0]  count_q;
	logic        done_q;
	logic [4:0]  b5, r5, g5;
	logic [5:0]  g6;

	assign b5 = cmd.b[7:3];
	assign r5 = cmd.r[7:3];
	assign g5 = cmd.g[7:3];
	assign g6 = cmd.g[7:2];

	always_comb begin
		case (cmd.fmt)
			FMT_555: word = {1'b0, r5, g5, b5};
			FMT_MIX: word = {1'b0, r5, 10'd0} | {5'd0, g6, b5};
			default: word = {r5, g6, b5};
		endcase
	end

	assign cmd_take = cmd_valid && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || pop) begin
			valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			word_q  <= word;
			count_q <= cmd.count;
			done_q  <= cmd.last;
		end
	end

	assign empty        = !valid_q;
	assign pixel_word   = word_q;
	assign repeat_count = count_q;
	assign frame_done   = done_q;

endmodule

// ----- design/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Run-length image payload decoder producing 16-bit pixels with repeat counts.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// input     push / full            command, data_byte
// result    pop / empty            pixel_word, repeat_count, frame_done
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while full is low; the byte that completes a pixel passes
// through the parser, the two-entry queue and the result register.
// full rises only when the queue holds two commands.
// Reset clears parser state and the budget: no result until a frame start.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder import tga_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             command,
	input  logic [7:0]       data_byte,
	output logic             empty,
	input  logic             pop,
	output logic [15:0]      pixel_word,
	output logic [7:0]       repeat_count,
	output logic             frame_done,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [PIX_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	logic     in_take, emit, q_full, q_empty, q_take;
	pix_cmd_t f_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_format <= FMT_555;
			cfg_q.image_kind   <= KIND_RAW;
			cfg_q.pixel_count  <= MAX_PIXELS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COLOR_FORMAT: cfg_q.color_format <= cfg_data[1:0];
				REG_IMAGE_KIND:   cfg_q.image_kind   <= cfg_data[1:0];
				REG_PIXEL_COUNT:  cfg_q.pixel_count  <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign full    = q_full;
	assign in_take = push && !q_full;

	tga_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_take),
		.command   (command),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.emit      (emit),
		.cmd       (f_cmd)
	);

	tga_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (emit),
		.wr_data (f_cmd),
		.rd_en   (q_take),
		.rd_data (q_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	tga_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (!q_empty),
		.cmd          (q_cmd),
		.cmd_take     (q_take),
		.pop          (pop),
		.empty        (empty),
		.pixel_word   (pixel_word),
		.repeat_count (repeat_count),
		.frame_done   (frame_done)
	);

endmodule
